[design/tdp_pkg.sv]
package tdp_pkg;

	// width of the number field on the input channel
	localparam int NUMBER_W = 32;

	// status of the shared remainder unit, as the sequencer sees it
	typedef struct packed {
		logic done;  // last step of the division is in this cycle
		logic zero;  // remainder after that step is zero
	} tdp_rem_stat_t;

endpackage

[design/tdp_num_if.sv]
interface tdp_num_if import tdp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [NUMBER_W-1:0] number;

	modport source (output valid, output number, input ready);
	modport sink (input valid, input number, output ready);
endinterface

[design/tdp_res_if.sv]
interface tdp_res_if;
	logic valid;
	logic ready;
	logic is_prime;

	modport source (output valid, output is_prime, input ready);
	modport sink (input valid, input is_prime, output ready);
endinterface

[design/tdp_rem_unit.sv]
module tdp_rem_unit import tdp_pkg::*; #(
	parameter int WIDTH = 32,
	parameter int DW    = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] n,
	input  logic [DW-1:0]    d,
	output tdp_rem_stat_t    stat
);

	localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

	logic             busy_q;
	logic [CW-1:0]    cnt_q;
	logic [DW-1:0]    rem_q;
	logic [WIDTH-1:0] n_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic [DW-1:0]    rem_next;

	// one restoring step: bring down the next bit, subtract when it fits
	assign trial    = {rem_q, n_q[WIDTH-1]};
	assign diff     = trial - {1'b0, d};
	assign rem_next = (trial >= {1'b0, d}) ? diff[DW-1:0] : trial[DW-1:0];

	assign stat.done = busy_q && (cnt_q == '0);
	assign stat.zero = (rem_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(WIDTH - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			n_q   <= n;
		end else if (busy_q) begin
			rem_q <= rem_next;
			n_q   <= n_q << 1;
		end
	end

endmodule

[design/trial_division_prime_test.sv]
// Trial-division primality tester.
//
// Channels: num (sink) takes one item carrying an unsigned number; res
// (source) returns one item carrying is_prime for it. Both use valid/ready
// and move an item on a rising edge where both are high. The number is read
// at WIDTH bits: higher bits drop, a narrower field is zero-extended.
//
// One item at a time: num.ready is high only while the block is empty.
// Flow after acceptance: a check state answers 0, 1, 2 and even numbers
// directly; otherwise the odd divisors 3, 5, 7, ... are tried in turn until
// one divides the number or the final bound check (divisor squared beyond
// the number) ends the search; the count k of divisors tried is at most
// about sqrt(n) / 2. Each divisor costs one bound check plus WIDTH steps of
// the shared one-bit-a-cycle remainder unit, which sets the rate.
//
// Reset (arst_n low) empties the block: no result is pending and num.ready
// is high, during reset and after it. A result waits in its register while
// res.ready is low; no new item is taken until it has been delivered.
module trial_division_prime_test import tdp_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	tdp_num_if.sink   num,
	tdp_res_if.source res
);

	localparam int DW = WIDTH / 2 + 2;  // divisor width, covers sqrt bound
	localparam int SW = WIDTH + 2;      // square of divisor

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_TEST  = 3'd2;
	localparam logic [2:0] S_DIV   = 3'd3;
	localparam logic [2:0] S_OUT   = 3'd4;

	logic [2:0]       state_q;
	logic [WIDTH-1:0] n_q;
	logic [DW-1:0]    d_q;
	logic [SW-1:0]    sq_q;
	logic             res_q;
	logic             start;
	tdp_rem_stat_t    rem_stat;

	assign num.ready    = (state_q == S_IDLE);
	assign res.valid    = (state_q == S_OUT);
	assign res.is_prime = res_q;

	// kick the remainder unit when the bound still allows a divisor
	assign start = (state_q == S_TEST) && !(sq_q > SW'(n_q));

	tdp_rem_unit #(
		.WIDTH (WIDTH),
		.DW    (DW)
	) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.n      (n_q),
		.d      (d_q),
		.stat   (rem_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (num.valid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					// small values and even numbers need no division
					if ((n_q < WIDTH'(2)) || (n_q == WIDTH'(2)) || !n_q[0]) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_TEST;
					end
				end
				S_TEST: begin
					// divisor squared beyond the number: nothing left to try
					state_q <= start ? S_DIV : S_OUT;
				end
				S_DIV: begin
					if (rem_stat.done) begin
						state_q <= rem_stat.zero ? S_OUT : S_TEST;
					end
				end
				S_OUT: begin
					if (res.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: number, divisor, its square and the answer
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (num.valid) begin
					n_q <= WIDTH'(num.number);
				end
			end
			S_CHECK: begin
				res_q <= (n_q == WIDTH'(2));
				d_q   <= DW'(3);
				sq_q  <= SW'(9);
			end
			S_TEST: begin
				if (!start) begin
					res_q <= 1'b1;
				end
			end
			S_DIV: begin
				if (rem_stat.done) begin
					if (rem_stat.zero) begin
						res_q <= 1'b0;
					end else begin
						// advance to the next odd divisor: (d+2)^2 = d^2 + 4d + 4
						d_q  <= d_q + DW'(2);
						sq_q <= sq_q + SW'({d_q, 2'b00}) + SW'(4);
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[design/tdp_checker.sv]
module tdp_checker import tdp_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                num_valid,
	input logic                num_ready,
	input logic [NUMBER_W-1:0] number,
	input logic                res_valid,
	input logic                res_ready,
	input logic                is_prime
);

	// a stalled result holds its value
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(is_prime))
		else $error("result changed while stalled");

	// no item is taken while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && num_ready |-> !res_valid)
		else $error("item accepted with result pending");

	// one item at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && num_ready |=> !num_ready)
		else $error("ready held after accept");

	// zero and one go through the check state straight to a not-prime result
	assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && num_ready && (number[NUMBER_W-1:1] == '0)
		|-> ##2 res_valid && !is_prime)
		else $error("zero or one not answered as not prime");

endmodule

bind trial_division_prime_test tdp_checker u_tdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.num_valid (num.valid),
	.num_ready (num.ready),
	.number    (num.number),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.is_prime  (res.is_prime)
);
